@@ rtl/core/cia_pkg.sv @@
// types, constants and arithmetic helpers shared by the complex arithmetic unit
`timescale 1ns / 1ps

package cia_pkg;

  localparam int DW = 32;
  localparam int FW = 16;
  localparam int PW = 2 * DW;
  localparam int EW = PW + 2;
  localparam int NW = PW + FW;
  localparam int QW = DW;

  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [EW-1:0] RND  = EW'({FW{1'b1}});
  localparam logic [QW-1:0]        QLIM_P = QW'(VMAX);
  localparam logic [QW-1:0]        QLIM_N = QW'(VMIN);

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_PAR = 3'd4,
    MODE_SER = 3'd5
  } mode_t;

  typedef struct packed {
    logic signed [DW-1:0] val;
    logic                 ovf;
  } sat_t;

  typedef struct packed {
    logic                 direct;
    logic signed [DW-1:0] d_re;
    logic signed [DW-1:0] d_im;
    logic                 ovf;
    logic                 zd_re;
    logic                 zd_im;
    logic                 zn_re;
    logic                 zn_im;
    logic                 neg_re;
    logic                 neg_im;
    logic                 big_re;
    logic                 big_im;
  } side_t;

  function automatic sat_t sat_fn(input logic signed [EW-1:0] v);
    sat_t r;
    if (v > EW'(VMAX)) begin
      r.val = VMAX;
      r.ovf = 1'b1;
    end else if (v < EW'(VMIN)) begin
      r.val = VMIN;
      r.ovf = 1'b1;
    end else begin
      r.val = v[DW-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // arithmetic shift by the fraction width, rounding toward zero
  function automatic logic signed [EW-1:0] shr_tz(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] t;
    t = v + (v[EW-1] ? RND : '0);
    return t >>> FW;
  endfunction

  function automatic sat_t fin_fn(input logic [QW-1:0] q, input logic big, input logic neg,
                                  input logic zd, input logic zn);
    sat_t r;
    if (zd) begin
      r.val = zn ? VMIN : VMAX;
      r.ovf = 1'b0;
    end else if (big || (neg ? (q > QLIM_N) : (q > QLIM_P))) begin
      r.val = neg ? VMIN : VMAX;
      r.ovf = 1'b1;
    end else begin
      r.val = $signed(neg ? (~q + 1'b1) : q);
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/cia_in_if.sv @@
// operand channel of the complex arithmetic unit
`timescale 1ns / 1ps

interface cia_in_if import cia_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [2:0]           mode;
  logic signed [DW-1:0] a_re;
  logic signed [DW-1:0] a_im;
  logic signed [DW-1:0] b_re;
  logic signed [DW-1:0] b_im;

  modport source (output valid, mode, a_re, a_im, b_re, b_im, input ready);
  modport sink (input valid, mode, a_re, a_im, b_re, b_im, output ready);
endinterface

@@ rtl/core/cia_out_if.sv @@
// result channel of the complex arithmetic unit
`timescale 1ns / 1ps

interface cia_out_if import cia_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] res_re;
  logic signed [DW-1:0] res_im;
  logic                 zero_divisor;
  logic                 overflow;

  modport source (output valid, res_re, res_im, zero_divisor, overflow, input ready);
  modport sink (input valid, res_re, res_im, zero_divisor, overflow, output ready);
endinterface

@@ rtl/core/complex_impedance_alu_core.sv @@
// Complex arithmetic unit on Q16.16 operands: add, subtract, multiply, divide, parallel
// combination and series-to-parallel conversion with saturation and divisor flags.
// One transaction is accepted every cycle unless the result side stalls. Each result passes
// through five multiply, sum and operand-prep stages, a 32-stage restoring divider that
// yields one quotient bit per stage, and the output register. Every mode takes the same
// path, so results leave in order. A stall on the result side freezes the whole pipeline.
`timescale 1ns / 1ps

module complex_impedance_alu_core import cia_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cia_in_if.sink    req,
  cia_out_if.source rsp
);

  logic en;
  assign en = !rsp.valid || rsp.ready;
  assign req.ready = en;

  logic v1, v2, v3, v4, v5;
  logic vd [1:QW];

  // stage 1: products and sums
  logic [2:0]           s1_mode;
  logic signed [DW-1:0] s1_a_re, s1_a_im, s1_b_re, s1_b_im;
  logic signed [PW-1:0] s1_m_rr, s1_m_ii, s1_m_ri, s1_m_ir;
  logic signed [DW:0]   s1_sum_re, s1_sum_im, s1_dif_re, s1_dif_im;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mode   <= req.mode;
      s1_a_re   <= req.a_re;
      s1_a_im   <= req.a_im;
      s1_b_re   <= req.b_re;
      s1_b_im   <= req.b_im;
      s1_m_rr   <= req.a_re * req.b_re;
      s1_m_ii   <= req.a_im * req.b_im;
      s1_m_ri   <= req.a_re * req.b_im;
      s1_m_ir   <= req.a_im * req.b_re;
      s1_sum_re <= {req.a_re[DW-1], req.a_re} + {req.b_re[DW-1], req.b_re};
      s1_sum_im <= {req.a_im[DW-1], req.a_im} + {req.b_im[DW-1], req.b_im};
      s1_dif_re <= {req.a_re[DW-1], req.a_re} - {req.b_re[DW-1], req.b_re};
      s1_dif_im <= {req.a_im[DW-1], req.a_im} - {req.b_im[DW-1], req.b_im};
    end
  end

  // stage 2: scale, saturate, direct results
  sat_t p_re, p_im, a_sr, a_si, d_sr, d_si;
  logic signed [DW-1:0] r2_re, r2_im;
  logic                 r2_ovf;

  always_comb begin
    p_re = sat_fn(shr_tz(EW'(s1_m_rr) - EW'(s1_m_ii)));
    p_im = sat_fn(shr_tz(EW'(s1_m_ri) + EW'(s1_m_ir)));
    a_sr = sat_fn(EW'(s1_sum_re));
    a_si = sat_fn(EW'(s1_sum_im));
    d_sr = sat_fn(EW'(s1_dif_re));
    d_si = sat_fn(EW'(s1_dif_im));
    r2_re  = '0;
    r2_im  = '0;
    r2_ovf = 1'b0;
    unique case (s1_mode)
      MODE_ADD: begin
        r2_re  = a_sr.val;
        r2_im  = a_si.val;
        r2_ovf = a_sr.ovf | a_si.ovf;
      end
      MODE_SUB: begin
        r2_re  = d_sr.val;
        r2_im  = d_si.val;
        r2_ovf = d_sr.ovf | d_si.ovf;
      end
      MODE_MUL: begin
        r2_re  = p_re.val;
        r2_im  = p_im.val;
        r2_ovf = p_re.ovf | p_im.ovf;
      end
      MODE_PAR: begin
        r2_ovf = p_re.ovf | p_im.ovf | a_sr.ovf | a_si.ovf;
      end
      default: begin
        r2_ovf = 1'b0;
      end
    endcase
  end

  logic [2:0]           s2_mode;
  logic signed [DW-1:0] s2_a_re, s2_a_im, s2_b_re, s2_b_im;
  logic signed [DW-1:0] s2_p_re, s2_p_im, s2_s_re, s2_s_im;
  logic signed [DW-1:0] s2_res_re, s2_res_im;
  logic                 s2_ovf;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mode   <= s1_mode;
      s2_a_re   <= s1_a_re;
      s2_a_im   <= s1_a_im;
      s2_b_re   <= s1_b_re;
      s2_b_im   <= s1_b_im;
      s2_p_re   <= p_re.val;
      s2_p_im   <= p_im.val;
      s2_s_re   <= a_sr.val;
      s2_s_im   <= a_si.val;
      s2_res_re <= r2_re;
      s2_res_im <= r2_im;
      s2_ovf    <= r2_ovf;
    end
  end

  // stage 3: quotient products
  logic signed [DW-1:0] x_re, x_im, y_re, y_im;

  always_comb begin
    unique case (s2_mode)
      MODE_PAR: begin
        x_re = s2_p_re;
        x_im = s2_p_im;
        y_re = s2_s_re;
        y_im = s2_s_im;
      end
      MODE_SER: begin
        x_re = s2_a_re;
        x_im = s2_a_im;
        y_re = s2_a_re;
        y_im = s2_a_im;
      end
      default: begin
        x_re = s2_a_re;
        x_im = s2_a_im;
        y_re = s2_b_re;
        y_im = s2_b_im;
      end
    endcase
  end

  logic [2:0]           s3_mode;
  logic signed [PW-1:0] s3_rr, s3_ii, s3_ir, s3_ri, s3_yr2, s3_yi2;
  logic signed [DW-1:0] s3_y_re, s3_y_im, s3_res_re, s3_res_im;
  logic                 s3_xn_re, s3_xn_im, s3_ovf;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_mode   <= s2_mode;
      s3_rr     <= x_re * y_re;
      s3_ii     <= x_im * y_im;
      s3_ir     <= x_im * y_re;
      s3_ri     <= x_re * y_im;
      s3_yr2    <= y_re * y_re;
      s3_yi2    <= y_im * y_im;
      s3_y_re   <= y_re;
      s3_y_im   <= y_im;
      s3_xn_re  <= x_re[DW-1];
      s3_xn_im  <= x_im[DW-1];
      s3_res_re <= s2_res_re;
      s3_res_im <= s2_res_im;
      s3_ovf    <= s2_ovf;
    end
  end

  // stage 4: numerators and denominator
  logic [2:0]           s4_mode;
  logic signed [EW-1:0] s4_nre, s4_nim;
  logic [PW-1:0]        s4_den;
  logic signed [DW-1:0] s4_y_re, s4_y_im, s4_res_re, s4_res_im;
  logic                 s4_xn_re, s4_xn_im, s4_ovf;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_mode   <= s3_mode;
      s4_nre    <= EW'(s3_rr) + EW'(s3_ii);
      s4_nim    <= EW'(s3_ir) - EW'(s3_ri);
      s4_den    <= $unsigned(s3_yr2) + $unsigned(s3_yi2);
      s4_y_re   <= s3_y_re;
      s4_y_im   <= s3_y_im;
      s4_xn_re  <= s3_xn_re;
      s4_xn_im  <= s3_xn_im;
      s4_res_re <= s3_res_re;
      s4_res_im <= s3_res_im;
      s4_ovf    <= s3_ovf;
    end
  end

  // stage 5: divider operands
  logic [EW-1:0] mag_re, mag_im;
  logic [NW-1:0] n_re, n_im;
  logic [PW-1:0] dv_re, dv_im;
  side_t         sd5;

  always_comb begin
    mag_re = s4_nre[EW-1] ? -s4_nre : s4_nre;
    mag_im = s4_nim[EW-1] ? -s4_nim : s4_nim;
    sd5.d_re = s4_res_re;
    sd5.d_im = s4_res_im;
    sd5.ovf  = s4_ovf;
    unique case (s4_mode)
      MODE_DIV, MODE_PAR: begin
        sd5.direct = 1'b0;
        n_re  = {mag_re[PW-1:0], {FW{1'b0}}};
        n_im  = {mag_im[PW-1:0], {FW{1'b0}}};
        dv_re = s4_den;
        dv_im = s4_den;
        sd5.neg_re = s4_nre[EW-1];
        sd5.neg_im = s4_nim[EW-1];
        sd5.zd_re  = (s4_den == '0);
        sd5.zd_im  = (s4_den == '0);
        sd5.zn_re  = s4_xn_re;
        sd5.zn_im  = s4_xn_im;
      end
      MODE_SER: begin
        sd5.direct = 1'b0;
        n_re  = NW'(s4_den);
        n_im  = NW'(s4_den);
        dv_re = PW'($unsigned(DW'(s4_y_re[DW-1] ? -s4_y_re : s4_y_re)));
        dv_im = PW'($unsigned(DW'(s4_y_im[DW-1] ? -s4_y_im : s4_y_im)));
        sd5.neg_re = s4_y_re[DW-1];
        sd5.neg_im = s4_y_im[DW-1];
        sd5.zd_re  = (s4_y_re == '0);
        sd5.zd_im  = (s4_y_im == '0);
        sd5.zn_re  = 1'b0;
        sd5.zn_im  = 1'b0;
      end
      default: begin
        sd5.direct = 1'b1;
        n_re  = '0;
        n_im  = '0;
        dv_re = '0;
        dv_im = '0;
        sd5.neg_re = 1'b0;
        sd5.neg_im = 1'b0;
        sd5.zd_re  = 1'b0;
        sd5.zd_im  = 1'b0;
        sd5.zn_re  = 1'b0;
        sd5.zn_im  = 1'b0;
      end
    endcase
    sd5.big_re = PW'(n_re[NW-1:QW]) >= dv_re;
    sd5.big_im = PW'(n_im[NW-1:QW]) >= dv_im;
  end

  logic [PW-1:0] s5_rem_re, s5_rem_im, s5_den_re, s5_den_im;
  logic [QW-1:0] s5_low_re, s5_low_im;
  side_t         s5_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_rem_re <= PW'(n_re[NW-1:QW]);
      s5_rem_im <= PW'(n_im[NW-1:QW]);
      s5_low_re <= n_re[QW-1:0];
      s5_low_im <= n_im[QW-1:0];
      s5_den_re <= dv_re;
      s5_den_im <= dv_im;
      s5_side   <= sd5;
    end
  end

  // divider lanes
  logic [QW-1:0] quo_re, quo_im;

  cia_div_lane u_div_re (
    .clk    (clk),
    .en     (en),
    .rem_in (s5_rem_re),
    .low_in (s5_low_re),
    .den_in (s5_den_re),
    .quo    (quo_re)
  );

  cia_div_lane u_div_im (
    .clk    (clk),
    .en     (en),
    .rem_in (s5_rem_im),
    .low_in (s5_low_im),
    .den_in (s5_den_im),
    .quo    (quo_im)
  );

  side_t sd [1:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      sd[1] <= s5_side;
      for (int k = 2; k <= QW; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  // final sign, saturation and flag merge
  sat_t f_re, f_im;
  logic signed [DW-1:0] o_re, o_im;
  logic                 o_zd, o_ovf;

  always_comb begin
    f_re = fin_fn(quo_re, sd[QW].big_re, sd[QW].neg_re, sd[QW].zd_re, sd[QW].zn_re);
    f_im = fin_fn(quo_im, sd[QW].big_im, sd[QW].neg_im, sd[QW].zd_im, sd[QW].zn_im);
    if (sd[QW].direct) begin
      o_re  = sd[QW].d_re;
      o_im  = sd[QW].d_im;
      o_zd  = 1'b0;
      o_ovf = sd[QW].ovf;
    end else begin
      o_re  = f_re.val;
      o_im  = f_im.val;
      o_zd  = sd[QW].zd_re | sd[QW].zd_im;
      o_ovf = sd[QW].ovf | f_re.ovf | f_im.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.res_re       <= o_re;
      rsp.res_im       <= o_im;
      rsp.zero_divisor <= o_zd;
      rsp.overflow     <= o_ovf;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      for (int k = 1; k <= QW; k++) begin
        vd[k] <= 1'b0;
      end
      rsp.valid <= 1'b0;
    end else if (en) begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      vd[1] <= v5;
      for (int k = 2; k <= QW; k++) begin
        vd[k] <= vd[k-1];
      end
      rsp.valid <= vd[QW];
    end
  end

`ifndef ASSERT_OFF
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |-> !req.ready)
    else $error("input accepted while result stalled");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !rsp.valid && !vd[QW] && !v1)
    else $error("pipeline not empty after reset");

  a_direct_no_zd: assert property (@(posedge clk) disable iff (rst)
    vd[QW] && sd[QW].direct |-> !(sd[QW].zd_re || sd[QW].zd_im))
    else $error("divisor flag on a non-dividing transaction");
`endif

endmodule

@@ rtl/core/cia_div_lane.sv @@
// pipelined restoring divider lane, one quotient bit per stage
`timescale 1ns / 1ps

module cia_div_lane import cia_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [PW-1:0] rem_in,
  input  logic [QW-1:0] low_in,
  input  logic [PW-1:0] den_in,
  output logic [QW-1:0] quo
);

  logic [PW-1:0] rem [1:QW];
  logic [QW-1:0] low [1:QW];
  logic [PW-1:0] den [1:QW];
  logic [QW-1:0] q   [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [PW-1:0] r_i;
    logic [QW-1:0] l_i;
    logic [PW-1:0] d_i;
    logic [QW-1:0] q_i;
    logic [PW:0]   trial;
    logic [PW:0]   diff;
    logic          take;

    if (k == 0) begin : g_first
      assign r_i = rem_in;
      assign l_i = low_in;
      assign d_i = den_in;
      assign q_i = '0;
    end else begin : g_next
      assign r_i = rem[k];
      assign l_i = low[k];
      assign d_i = den[k];
      assign q_i = q[k];
    end

    assign trial = {r_i, l_i[QW-1]};
    assign diff  = trial - {1'b0, d_i};
    assign take  = !diff[PW];

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= take ? diff[PW-1:0] : trial[PW-1:0];
        low[k+1] <= {l_i[QW-2:0], 1'b0};
        den[k+1] <= d_i;
        q[k+1]   <= {q_i[QW-2:0], take};
      end
    end
  end

  assign quo = q[QW];

endmodule
